### src/hfp_pkg.sv
package hfp_pkg;

	localparam int PROB_W = 16;
	localparam int MANT_W = 24;
	localparam int EXP_W  = 16;
	localparam int KIND_W = 2;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

	typedef enum logic [KIND_W-1:0] {
		KIND_INIT  = 2'd0,
		KIND_TRANS = 2'd1,
		KIND_EMIS  = 2'd2,
		KIND_OBS   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic [PROB_W-1:0]  prob;
		logic [IDX_W-1:0]   symbol;
		logic               start_req;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   state_index;
		logic [MANT_W-1:0]  mantissa;
		logic [EXP_W-1:0]   exponent;
		logic               last;
	} result_t;

endpackage

### src/hfp_item_if.sv
interface hfp_item_if
	import hfp_pkg::*;
();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/hfp_result_if.sv
interface hfp_result_if
	import hfp_pkg::*;
();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/hfp_cfg_if.sv
interface hfp_cfg_if
	import hfp_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/hfp_ram.sv
module hfp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/hmm_forward_probability_unit.sv
// Forward recursion of a hidden Markov model with block-floating alpha. Load beats (initial,
// transition, emission) are taken only while idle. An observe beat runs through one shared 24x16
// multiply-accumulate unit fed from the transition and emission RAMs: a start symbol makes one
// initial-times-emission product per state in use, any other symbol per state n transition
// products and then one emission product, where n is the number of states in use. Normalizing
// then shifts the largest mantissa one bit per cycle, and the n results leave one per cycle
// through an output register while the output side accepts them. A new beat is taken once the
// last result of the previous one is in the output register.
module hmm_forward_probability_unit
	import hfp_pkg::*;
#(
	parameter int STATES  = 8,
	parameter int SYMBOLS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	hfp_item_if.sink     item,
	hfp_result_if.source result,
	hfp_cfg_if.sink      cfg
);

	localparam int SI_W   = $clog2(STATES);
	localparam int TA_W   = $clog2(STATES * STATES);
	localparam int EA_W   = $clog2(SYMBOLS * STATES);
	localparam int PROD_W = MANT_W + PROB_W;
	localparam int ACC_W  = PROD_W + $clog2(STATES);
	localparam int SH_W   = $clog2(MANT_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_GAP,
		S_EMIS,
		S_DRAIN,
		S_NORM,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_INIT,
		OP_TRANS,
		OP_EMIS
	} op_kind_t;

	typedef struct packed {
		logic            vld;
		op_kind_t        kind;
		logic            first;
		logic [SI_W-1:0] idx;
	} op_t;

	state_t            state_q;
	logic [CFG_W-1:0]  cfg_q;
	logic [SI_W-1:0]   i_q;
	logic [SI_W-1:0]   k_q;
	logic [SI_W-1:0]   last_q;
	logic [IDX_W-1:0]  sym_q;
	logic              sym_ok_q;
	logic              start_q;
	logic [MANT_W-1:0] max_q;
	logic [SH_W-1:0]   shift_q;
	logic [EXP_W-1:0]  exp_q;
	logic [MANT_W-1:0] alpha_q [STATES];
	logic              out_vld_q;
	result_t           out_q;

	op_t               op_s1;
	op_t               op_s2;
	logic [MANT_W-1:0] alpha_s1;
	logic [PROB_W-1:0] init_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [PROB_W-1:0] e_q;
	logic [ACC_W-1:0]  acc_q;
	logic [MANT_W-1:0] next_q [STATES];
	logic [PROB_W-1:0] init_q [STATES];

	logic              in_acc;
	logic              obs_acc;
	logic              init_we;
	logic              t_we;
	logic              e_we;
	logic [TA_W-1:0]   t_waddr;
	logic [EA_W-1:0]   e_waddr;
	logic [TA_W-1:0]   t_raddr;
	logic [EA_W-1:0]   e_raddr;
	logic [PROB_W-1:0] t_rdata;
	logic [PROB_W-1:0] e_rdata;
	logic [PROB_W-1:0] e_val;
	logic [SI_W-1:0]   act_last;
	op_t               issue_op;
	logic [MANT_W-1:0] sat_t;
	logic [MANT_W-1:0] mul_a;
	logic [PROB_W-1:0] mul_b;
	logic [PROD_W-1:0] mul_p;
	logic [MANT_W-1:0] nv;
	logic [MANT_W-1:0] shifted;
	logic [EXP_W:0]    exp_sum;

	assign item.ready   = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	assign in_acc  = item.valid && item.ready;
	assign obs_acc = in_acc && (item.data.kind == KIND_OBS);

	// table loads, out-of-range indexes are dropped
	assign init_we = in_acc && (item.data.kind == KIND_INIT) && (32'(item.data.row) < STATES);
	assign t_we    = in_acc && (item.data.kind == KIND_TRANS)
		&& (32'(item.data.row) < STATES) && (32'(item.data.col) < STATES);
	assign e_we    = in_acc && (item.data.kind == KIND_EMIS)
		&& (32'(item.data.row) < SYMBOLS) && (32'(item.data.col) < STATES);
	assign t_waddr = TA_W'(32'(item.data.row) * STATES + 32'(item.data.col));
	assign e_waddr = EA_W'(32'(item.data.row) * STATES + 32'(item.data.col));

	assign t_raddr = TA_W'(32'(i_q) * STATES + 32'(k_q));
	assign e_raddr = EA_W'(32'(sym_q) * STATES + 32'(i_q));

	hfp_ram #(.WIDTH(PROB_W), .DEPTH(STATES * STATES)) u_trans_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (item.data.prob),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	hfp_ram #(.WIDTH(PROB_W), .DEPTH(SYMBOLS * STATES)) u_emis_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (item.data.prob),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	assign e_val = sym_ok_q ? e_rdata : '0;

	// zero states acts as one, too many acts as all
	always_comb begin
		if (cfg_q == '0) begin
			act_last = '0;
		end else if (32'(cfg_q) > STATES) begin
			act_last = SI_W'(STATES - 1);
		end else begin
			act_last = SI_W'(cfg_q - CFG_W'(1));
		end
	end

	always_comb begin
		issue_op       = '0;
		issue_op.idx   = i_q;
		issue_op.first = (k_q == '0);
		case (state_q)
			S_ISSUE: begin
				issue_op.vld  = 1'b1;
				issue_op.kind = start_q ? OP_INIT : OP_TRANS;
			end
			S_EMIS: begin
				issue_op.vld  = 1'b1;
				issue_op.kind = OP_EMIS;
			end
			default: begin
				issue_op.vld = 1'b0;
			end
		endcase
	end

	// row sum truncated to q0.24 and saturated
	assign sat_t = (|acc_q[ACC_W-1:PROD_W]) ? '1 : acc_q[PROD_W-1:PROB_W];

	always_comb begin
		case (op_s1.kind)
			OP_TRANS: begin
				mul_a = alpha_s1;
				mul_b = t_rdata;
			end
			OP_INIT: begin
				mul_a = MANT_W'(init_s1);
				mul_b = e_val;
			end
			OP_EMIS: begin
				mul_a = sat_t;
				mul_b = e_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign nv = (op_s2.kind == OP_INIT) ? prod_s2[2*PROB_W-1:2*PROB_W-MANT_W]
		: prod_s2[PROD_W-1:PROB_W];

	assign shifted = next_q[i_q] << shift_q;
	assign exp_sum = {1'b0, exp_q} + (EXP_W + 1)'(shift_q);

	// datapath: operand fetch, product, accumulate
	always_ff @(posedge clk) begin
		alpha_s1 <= alpha_q[k_q];
		init_s1  <= init_q[i_q];
		prod_s2  <= mul_p;
		if (init_we) begin
			init_q[SI_W'(item.data.row)] <= item.data.prob;
		end
		if (op_s1.vld && (op_s1.kind == OP_TRANS) && op_s1.first) begin
			e_q <= e_val;
		end
		if (op_s2.vld && (op_s2.kind == OP_TRANS)) begin
			acc_q <= (op_s2.first ? '0 : acc_q) + ACC_W'(prod_s2);
		end
		if (obs_acc) begin
			for (int j = 0; j < STATES; j++) begin
				next_q[j] <= '0;
			end
		end else if (op_s2.vld && (op_s2.kind != OP_TRANS)) begin
			next_q[op_s2.idx] <= nv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cfg_q     <= CFG_RESET;
			i_q       <= '0;
			k_q       <= '0;
			last_q    <= '0;
			sym_q     <= '0;
			sym_ok_q  <= 1'b0;
			start_q   <= 1'b0;
			max_q     <= '0;
			shift_q   <= '0;
			exp_q     <= '0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
			op_s1     <= '0;
			op_s2     <= '0;
			for (int j = 0; j < STATES; j++) begin
				alpha_q[j] <= '0;
			end
		end else begin
			op_s1 <= issue_op;
			op_s2 <= op_s1;
			if (cfg.valid && cfg.ready) begin
				cfg_q <= cfg.data;
			end
			if (result.valid && result.ready && (state_q != S_OUT)) begin
				out_vld_q <= 1'b0;
			end
			if (op_s2.vld && (op_s2.kind != OP_TRANS) && (nv > max_q)) begin
				max_q <= nv;
			end
			case (state_q)
				S_IDLE: begin
					if (obs_acc) begin
						i_q      <= '0;
						k_q      <= '0;
						last_q   <= act_last;
						sym_q    <= item.data.symbol;
						sym_ok_q <= (32'(item.data.symbol) < SYMBOLS);
						start_q  <= item.data.start_req;
						max_q    <= '0;
						shift_q  <= '0;
						state_q  <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (start_q) begin
						if (i_q == last_q) begin
							state_q <= S_DRAIN;
						end else begin
							i_q <= i_q + SI_W'(1);
						end
					end else if (k_q == last_q) begin
						k_q     <= '0;
						state_q <= S_GAP;
					end else begin
						k_q <= k_q + SI_W'(1);
					end
				end
				// lets the last product of the row reach the accumulator
				S_GAP: begin
					state_q <= S_EMIS;
				end
				S_EMIS: begin
					if (i_q == last_q) begin
						state_q <= S_DRAIN;
					end else begin
						i_q     <= i_q + SI_W'(1);
						state_q <= S_ISSUE;
					end
				end
				S_DRAIN: begin
					if (!op_s1.vld && !op_s2.vld) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if ((max_q == '0) || max_q[MANT_W-1]) begin
						if (start_q) begin
							exp_q <= EXP_W'(shift_q);
						end else begin
							exp_q <= exp_sum[EXP_W] ? '1 : exp_sum[EXP_W-1:0];
						end
						i_q     <= '0;
						state_q <= S_OUT;
					end else begin
						max_q   <= max_q << 1;
						shift_q <= shift_q + SH_W'(1);
					end
				end
				S_OUT: begin
					if (!out_vld_q || result.ready) begin
						out_vld_q         <= 1'b1;
						out_q.state_index <= IDX_W'(i_q);
						out_q.mantissa    <= shifted;
						out_q.exponent    <= exp_q;
						out_q.last        <= (i_q == last_q);
						alpha_q[i_q]      <= shifted;
						if (i_q == last_q) begin
							// states not in use drop to zero
							for (int j = 0; j < STATES; j++) begin
								if (SI_W'(j) > last_q) begin
									alpha_q[j] <= '0;
								end
							end
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + SI_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
